### design/lwcg_pkg.sv
// Package: shared types, command codes and register indexes for the LCD window command generator.
`timescale 1ns / 1ps

package lwcg_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_BITS     = 16;
    localparam int DIM_BITS       = 12;
    localparam int CFG_IDX_BITS   = 3;
    localparam int BYTE_IDX_BITS  = 4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_OFFSET = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BGR_ORDER     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROTATION      = 3'd5;

    // register reset values
    localparam logic [DIM_BITS-1:0] PANEL_WIDTH_RST  = 12'd240;
    localparam logic [DIM_BITS-1:0] PANEL_HEIGHT_RST = 12'd320;

    // display command bytes
    localparam logic [7:0] CMD_CASET  = 8'h2A;
    localparam logic [7:0] CMD_RASET  = 8'h2B;
    localparam logic [7:0] CMD_RAMWR  = 8'h2C;
    localparam logic [7:0] CMD_MADCTL = 8'h36;

    // orientation byte bits
    localparam logic [7:0] MAD_MY  = 8'h80;
    localparam logic [7:0] MAD_MX  = 8'h40;
    localparam logic [7:0] MAD_MV  = 8'h20;
    localparam logic [7:0] MAD_BGR = 8'h08;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED = 2'd2;

    // request types
    localparam logic REQ_WINDOW = 1'b0;
    localparam logic REQ_ORIENT = 1'b1;

    // byte positions in the window sequence
    localparam logic [BYTE_IDX_BITS-1:0] WIN_CASET_IDX = 4'd0;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_XS_HI_IDX = 4'd1;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_XS_LO_IDX = 4'd2;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_XE_HI_IDX = 4'd3;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_XE_LO_IDX = 4'd4;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_RASET_IDX = 4'd5;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_YS_HI_IDX = 4'd6;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_YS_LO_IDX = 4'd7;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_YE_HI_IDX = 4'd8;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_YE_LO_IDX = 4'd9;
    localparam logic [BYTE_IDX_BITS-1:0] WIN_RAMWR_IDX = 4'd10;
    localparam logic [BYTE_IDX_BITS-1:0] ORI_CMD_IDX   = 4'd0;

    typedef enum logic [1:0] {
        FRAME_WINDOW,
        FRAME_ORIENT,
        FRAME_ERROR
    } frame_kind_t;

    typedef struct packed {
        logic                  req_type;
        logic [FIELD_BITS-1:0] win_x0;
        logic [FIELD_BITS-1:0] win_y0;
        logic [FIELD_BITS-1:0] win_x1;
        logic [FIELD_BITS-1:0] win_y1;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic [1:0] status;
        logic       last_byte;
    } rsp_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] panel_width;
        logic [DIM_BITS-1:0] panel_height;
        logic [DIM_BITS-1:0] column_offset;
        logic [DIM_BITS-1:0] row_offset;
        logic                bgr_order;
        logic [1:0]          rotation;
    } cfg_t;

    // everything the serializer needs to replay one request
    typedef struct packed {
        frame_kind_t           kind;
        logic [1:0]            status;
        logic [7:0]            mad;
        logic [FIELD_BITS-1:0] xs;
        logic [FIELD_BITS-1:0] xe;
        logic [FIELD_BITS-1:0] ys;
        logic [FIELD_BITS-1:0] ye;
    } frame_t;

endpackage

### design/lcd_window_command_generator.sv
// Top level: LCD window and orientation command generator.
`timescale 1ns / 1ps

// Turns display requests into the command/data byte stream of a MIPI-DBI style
// LCD controller. A window request gives CASET, four address bytes, RASET, four
// address bytes and RAMWR (eleven items); an orientation request gives MADCTL and
// its data byte (two items); a reversed window, a zero-size screen or a window
// starting off screen gives one error item with a status code. A request is taken
// into an input register, decoded combinationally into the result register once the
// serializer is free, and then sent one byte per cycle while rsp_ready is high; the
// input register takes the next request while the previous one is still being sent.
// Rotation, panel size, RAM offsets and BGR order are written on the cfg port while
// the block is idle; they apply to requests accepted afterwards.

module lcd_window_command_generator #(
    parameter int COORD_BITS = lwcg_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lwcg_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [lwcg_pkg::DIM_BITS-1:0]     cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  lwcg_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output lwcg_pkg::rsp_t                    rsp
);
    import lwcg_pkg::*;

    cfg_t   cfg;
    req_t   req_reg;
    logic   req_valid_reg;
    logic   req_valid_next;
    frame_t frame;
    logic   ser_free;
    logic   load;

    lwcg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // decode from the input register
    lwcg_window #(
        .COORD_BITS (COORD_BITS)
    ) u_window (
        .req   (req_reg),
        .cfg   (cfg),
        .frame (frame)
    );

    // a held request moves on once the serializer has sent (or is sending) its last byte
    assign load      = req_valid_reg && ser_free;
    assign req_ready = !req_valid_reg || load;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_valid && req_ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (load)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
    end

    lwcg_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .frame     (frame),
        .free      (ser_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### design/lwcg_cfg_regs.sv
// Configuration register file with write decode.
`timescale 1ns / 1ps

module lwcg_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lwcg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lwcg_pkg::DIM_BITS-1:0]        cfg_data,
    output lwcg_pkg::cfg_t                       cfg
);
    import lwcg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PANEL_WIDTH:   cfg_next.panel_width   = cfg_data;
                REG_PANEL_HEIGHT:  cfg_next.panel_height  = cfg_data;
                REG_COLUMN_OFFSET: cfg_next.column_offset = cfg_data;
                REG_ROW_OFFSET:    cfg_next.row_offset    = cfg_data;
                REG_BGR_ORDER:     cfg_next.bgr_order     = cfg_data[0];
                REG_ROTATION:      cfg_next.rotation      = cfg_data[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width   <= PANEL_WIDTH_RST;
            cfg_reg.panel_height  <= PANEL_HEIGHT_RST;
            cfg_reg.column_offset <= '0;
            cfg_reg.row_offset    <= '0;
            cfg_reg.bgr_order     <= 1'b0;
            cfg_reg.rotation      <= ROT_0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/lwcg_window.sv
// Request decode: window check, clipping, offset add and orientation byte.
`timescale 1ns / 1ps

module lwcg_window #(
    parameter int COORD_BITS = lwcg_pkg::COORD_BITS_DEF
) (
    input  lwcg_pkg::req_t   req,
    input  lwcg_pkg::cfg_t   cfg,
    output lwcg_pkg::frame_t frame
);
    import lwcg_pkg::*;

    logic                  swapped;
    logic [DIM_BITS-1:0]   log_w;
    logic [DIM_BITS-1:0]   log_h;
    logic [DIM_BITS-1:0]   off_x;
    logic [DIM_BITS-1:0]   off_y;
    logic [FIELD_BITS-1:0] w_ext;
    logic [FIELD_BITS-1:0] h_ext;
    logic [FIELD_BITS-1:0] x0;
    logic [FIELD_BITS-1:0] y0;
    logic [FIELD_BITS-1:0] x1;
    logic [FIELD_BITS-1:0] y1;
    logic [FIELD_BITS-1:0] x1_clip;
    logic [FIELD_BITS-1:0] y1_clip;
    logic                  bad;
    logic                  outside;
    logic [7:0]            mad;

    // odd rotations swap the axes, offsets included
    assign swapped = cfg.rotation[0];
    assign log_w   = swapped ? cfg.panel_height : cfg.panel_width;
    assign log_h   = swapped ? cfg.panel_width  : cfg.panel_height;
    assign off_x   = swapped ? cfg.row_offset   : cfg.column_offset;
    assign off_y   = swapped ? cfg.column_offset : cfg.row_offset;
    assign w_ext   = FIELD_BITS'(log_w);
    assign h_ext   = FIELD_BITS'(log_h);

    // only the low COORD_BITS of each corner count
    assign x0 = FIELD_BITS'(req.win_x0[COORD_BITS-1:0]);
    assign y0 = FIELD_BITS'(req.win_y0[COORD_BITS-1:0]);
    assign x1 = FIELD_BITS'(req.win_x1[COORD_BITS-1:0]);
    assign y1 = FIELD_BITS'(req.win_y1[COORD_BITS-1:0]);

    assign bad     = (log_w == '0) || (log_h == '0) || (x1 < x0) || (y1 < y0);
    assign outside = (x0 >= w_ext) || (y0 >= h_ext);
    assign x1_clip = (x1 >= w_ext) ? (w_ext - FIELD_BITS'(1)) : x1;
    assign y1_clip = (y1 >= h_ext) ? (h_ext - FIELD_BITS'(1)) : y1;

    always_comb
    begin
        case (cfg.rotation)
            ROT_0:   mad = 8'h00;
            ROT_90:  mad = MAD_MX | MAD_MV;
            ROT_180: mad = MAD_MX | MAD_MY;
            ROT_270: mad = MAD_MV | MAD_MY;
            default: mad = 8'h00;
        endcase
        if (cfg.bgr_order)
        begin
            mad = mad | MAD_BGR;
        end
    end

    // results stay below 8190, so 16-bit sums never wrap
    always_comb
    begin
        frame.mad = mad;
        frame.xs  = x0 + FIELD_BITS'(off_x);
        frame.xe  = x1_clip + FIELD_BITS'(off_x);
        frame.ys  = y0 + FIELD_BITS'(off_y);
        frame.ye  = y1_clip + FIELD_BITS'(off_y);
        if (req.req_type == REQ_ORIENT)
        begin
            frame.kind   = FRAME_ORIENT;
            frame.status = STATUS_OK;
        end
        else if (bad)
        begin
            frame.kind   = FRAME_ERROR;
            frame.status = STATUS_INVALID;
        end
        else if (outside)
        begin
            frame.kind   = FRAME_ERROR;
            frame.status = STATUS_SKIPPED;
        end
        else
        begin
            frame.kind   = FRAME_WINDOW;
            frame.status = STATUS_OK;
        end
    end

endmodule

### design/lwcg_serializer.sv
// Result register and byte sequencer: replays one decoded request as a byte stream.
`timescale 1ns / 1ps

module lwcg_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lwcg_pkg::frame_t frame,
    output logic             free,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output lwcg_pkg::rsp_t   rsp
);
    import lwcg_pkg::*;

    frame_t                   frame_reg;
    logic                     valid_reg;
    logic                     valid_next;
    logic [BYTE_IDX_BITS-1:0] idx_reg;
    logic [BYTE_IDX_BITS-1:0] idx_next;
    logic                     fire;
    logic                     done;

    // byte selection for the current position
    always_comb
    begin
        rsp = '0;
        case (frame_reg.kind)
            FRAME_WINDOW:
            begin
                case (idx_reg)
                    WIN_CASET_IDX: rsp.out_byte = CMD_CASET;
                    WIN_XS_HI_IDX: rsp.out_byte = frame_reg.xs[15:8];
                    WIN_XS_LO_IDX: rsp.out_byte = frame_reg.xs[7:0];
                    WIN_XE_HI_IDX: rsp.out_byte = frame_reg.xe[15:8];
                    WIN_XE_LO_IDX: rsp.out_byte = frame_reg.xe[7:0];
                    WIN_RASET_IDX: rsp.out_byte = CMD_RASET;
                    WIN_YS_HI_IDX: rsp.out_byte = frame_reg.ys[15:8];
                    WIN_YS_LO_IDX: rsp.out_byte = frame_reg.ys[7:0];
                    WIN_YE_HI_IDX: rsp.out_byte = frame_reg.ye[15:8];
                    WIN_YE_LO_IDX: rsp.out_byte = frame_reg.ye[7:0];
                    WIN_RAMWR_IDX: rsp.out_byte = CMD_RAMWR;
                    default:       rsp.out_byte = 8'h00;
                endcase
                rsp.is_command = (idx_reg == WIN_CASET_IDX) || (idx_reg == WIN_RASET_IDX)
                                 || (idx_reg == WIN_RAMWR_IDX);
                rsp.last_byte  = (idx_reg == WIN_RAMWR_IDX);
                rsp.status     = STATUS_OK;
            end
            FRAME_ORIENT:
            begin
                rsp.is_command = (idx_reg == ORI_CMD_IDX);
                rsp.out_byte   = rsp.is_command ? CMD_MADCTL : frame_reg.mad;
                rsp.last_byte  = !rsp.is_command;
                rsp.status     = STATUS_OK;
            end
            FRAME_ERROR:
            begin
                rsp.status    = frame_reg.status;
                rsp.last_byte = 1'b1;
            end
            default:
            begin
                rsp.last_byte = 1'b1;
            end
        endcase
    end

    assign rsp_valid = valid_reg;
    assign fire      = valid_reg && rsp_ready;
    assign done      = fire && rsp.last_byte;
    assign free      = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
            idx_next   = '0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + BYTE_IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame;
        end
    end

endmodule
